// ===== rtl/lif_neuron_surrogate_gradient_defines.svh =====
// ----------------------------------------------------------------------------
// lif neuron surrogate gradient assertion macros
// shared concurrent assertion forms for the neuron block
// ----------------------------------------------------------------------------
`ifndef LIF_NEURON_SURROGATE_GRADIENT_DEFINES_SVH
`define LIF_NEURON_SURROGATE_GRADIENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LIFSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LIFSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lifsg_pkg.sv =====
// ----------------------------------------------------------------------------
// lifsg_pkg
// types, register indexes and fixed widths of the lif neuron block
// ----------------------------------------------------------------------------
package lifsg_pkg;

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int DECAY_W    = 16;
   localparam int GAIN_W     = 24;
   localparam int STEPS_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int GAIN_FRAC  = 16;
   localparam int IN_FRAC    = 16;
   localparam int SG_EXTRA   = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_V          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_V_THRESHOLD      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_V_FLOOR          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY_STEPS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SG_SLOPE         = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_CURRENT     = 3'd7;

   // register reset values
   localparam logic [DECAY_W-1:0] RST_DECAY_V          = 16'd64881;
   localparam logic [GAIN_W-1:0]  RST_CURRENT_GAIN     = 24'd26;
   localparam logic [GAIN_W-1:0]  RST_SPIKE_GAIN       = 24'd65536;
   localparam logic [DATA_W-1:0]  RST_V_THRESHOLD      = 32'd983040;
   localparam logic [DATA_W-1:0]  RST_V_FLOOR          = 32'h8000_0000;
   localparam logic [STEPS_W-1:0] RST_REFRACTORY_STEPS = 16'd20;
   localparam logic [DATA_W-1:0]  RST_SG_SLOPE         = 32'd5726623;
   localparam logic [DATA_W-1:0]  RST_BIAS_CURRENT     = 32'd0;

   // configuration register set
   typedef struct packed {
      logic [DECAY_W-1:0] decay_v;
      logic [GAIN_W-1:0]  current_gain;
      logic [GAIN_W-1:0]  spike_gain;
      logic [DATA_W-1:0]  v_threshold;
      logic [DATA_W-1:0]  v_floor;
      logic [STEPS_W-1:0] refractory_steps;
      logic [DATA_W-1:0]  sg_slope;
      logic [DATA_W-1:0]  bias_current;
   } csr_type;

   // controller commands to the datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic finish;
   } cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_SURR
   } state_type;

endpackage

// ===== rtl/lif_neuron_surrogate_gradient.sv =====
// pipeline: an accepted word passes product capture, membrane update and the surrogate
// multiply into the output register; the last step waits while the output word is held
// input: a new word is taken while the previous result is handed off, never during the
// membrane update, since the next tick's decay product needs the membrane written there
// reset: synchronous, clears neuron state, output valid and loads register defaults
// ----------------------------------------------------------------------------
// lif_neuron_surrogate_gradient
// leaky integrate-and-fire neuron tick with piecewise-linear surrogate gradient
// ----------------------------------------------------------------------------
module lif_neuron_surrogate_gradient #(
   parameter int VALUE_WIDTH      = 32,
   parameter int FRAC_BITS        = 16,
   parameter int REFRACTORY_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,  // spike_input, current_input
   input  logic                             req_tuser,  // clear_state
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata,  // membrane_out, surrogate_out
   output logic                             rsp_tuser,  // spike_out
   // configuration write port
   input  logic                             csr_we,
   input  logic [lifsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lifsg_pkg::DATA_W-1:0]     csr_wdata
);

   lifsg_pkg::csr_type csr;
   lifsg_pkg::cmd_type cmd;
   logic [lifsg_pkg::DATA_W-1:0] membrane_out;
   logic [lifsg_pkg::DATA_W-1:0] surrogate_out;

   // configuration registers
   lifsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   // sequencer
   lifsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath
   lifsg_dp #(
      .VALUE_WIDTH      (VALUE_WIDTH),
      .FRAC_BITS        (FRAC_BITS),
      .REFRACTORY_WIDTH (REFRACTORY_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr               (csr),
      .req_spike_input   (req_tdata[31:0]),
      .req_current_input (req_tdata[63:32]),
      .req_clear_state   (req_tuser),
      .rsp_spike_out     (rsp_tuser),
      .rsp_membrane_out  (membrane_out),
      .rsp_surrogate_out (surrogate_out)
   );

   assign rsp_tdata = {surrogate_out, membrane_out};

endmodule

// ===== rtl/lifsg_csr.sv =====
// ----------------------------------------------------------------------------
// lifsg_csr
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module lifsg_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lifsg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lifsg_pkg::DATA_W-1:0]         csr_wdata,
   output lifsg_pkg::csr_type                   csr
);

   lifsg_pkg::csr_type regs_ff;
   lifsg_pkg::csr_type regs_in;

   // write decode
   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         case (csr_index)
            lifsg_pkg::CSR_DECAY_V:
               regs_in.decay_v = csr_wdata[lifsg_pkg::DECAY_W-1:0];
            lifsg_pkg::CSR_CURRENT_GAIN:
               regs_in.current_gain = csr_wdata[lifsg_pkg::GAIN_W-1:0];
            lifsg_pkg::CSR_SPIKE_GAIN:
               regs_in.spike_gain = csr_wdata[lifsg_pkg::GAIN_W-1:0];
            lifsg_pkg::CSR_V_THRESHOLD:
               regs_in.v_threshold = csr_wdata;
            lifsg_pkg::CSR_V_FLOOR:
               regs_in.v_floor = csr_wdata;
            lifsg_pkg::CSR_REFRACTORY_STEPS:
               regs_in.refractory_steps = csr_wdata[lifsg_pkg::STEPS_W-1:0];
            lifsg_pkg::CSR_SG_SLOPE:
               regs_in.sg_slope = csr_wdata;
            lifsg_pkg::CSR_BIAS_CURRENT:
               regs_in.bias_current = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.decay_v          <= lifsg_pkg::RST_DECAY_V;
         regs_ff.current_gain     <= lifsg_pkg::RST_CURRENT_GAIN;
         regs_ff.spike_gain       <= lifsg_pkg::RST_SPIKE_GAIN;
         regs_ff.v_threshold      <= lifsg_pkg::RST_V_THRESHOLD;
         regs_ff.v_floor          <= lifsg_pkg::RST_V_FLOOR;
         regs_ff.refractory_steps <= lifsg_pkg::RST_REFRACTORY_STEPS;
         regs_ff.sg_slope         <= lifsg_pkg::RST_SG_SLOPE;
         regs_ff.bias_current     <= lifsg_pkg::RST_BIAS_CURRENT;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr = regs_ff;

endmodule

// ===== rtl/lifsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lifsg_ctrl
// tick sequencer: capture, membrane update, surrogate and result hand-off
// ----------------------------------------------------------------------------
`include "lif_neuron_surrogate_gradient_defines.svh"

module lifsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lifsg_pkg::cmd_type   cmd
);

   lifsg_pkg::state_type state_ff;
   lifsg_pkg::state_type state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_free;
   logic                 accept;

   // output word slot is free or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // handshake and command outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd.update  = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         lifsg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         lifsg_pkg::ST_SUM: begin
            cmd.update = 1'b1;
         end
         lifsg_pkg::ST_SURR: begin
            req_tready = out_free;
            cmd.finish = out_free;
         end
         default: begin
         end
      endcase
      cmd.capture = req_tvalid && req_tready;
   end

   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lifsg_pkg::ST_IDLE: begin
            if (accept) state_in = lifsg_pkg::ST_SUM;
         end
         lifsg_pkg::ST_SUM: begin
            state_in = lifsg_pkg::ST_SURR;
         end
         lifsg_pkg::ST_SURR: begin
            if (out_free) begin
               state_in = accept ? lifsg_pkg::ST_SUM : lifsg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lifsg_pkg::ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lifsg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // checks
   `LIFSG_ASSERT_NEXT(a_finish_shows_word, clock, reset, cmd.finish, rsp_valid_ff, "finished word not presented")
   `LIFSG_ASSERT_NOW(a_sum_after_capture, clock, reset, state_ff == lifsg_pkg::ST_SUM, $past(cmd.capture), "update without a captured word")
   `LIFSG_ASSERT_NOW(a_no_capture_in_sum, clock, reset, cmd.capture, !cmd.update, "capture overlaps membrane update")

endmodule

// ===== rtl/lifsg_dp.sv =====
// ----------------------------------------------------------------------------
// lifsg_dp
// neuron datapath: gain products, membrane update, surrogate gradient
// ----------------------------------------------------------------------------
`include "lif_neuron_surrogate_gradient_defines.svh"

module lifsg_dp #(
   parameter int VALUE_WIDTH      = 32,
   parameter int FRAC_BITS        = 16,
   parameter int REFRACTORY_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lifsg_pkg::cmd_type                cmd,
   input  lifsg_pkg::csr_type                csr,
   input  logic [lifsg_pkg::DATA_W-1:0]      req_spike_input,
   input  logic [lifsg_pkg::DATA_W-1:0]      req_current_input,
   input  logic                              req_clear_state,
   output logic                              rsp_spike_out,
   output logic [lifsg_pkg::DATA_W-1:0]      rsp_membrane_out,
   output logic [lifsg_pkg::DATA_W-1:0]      rsp_surrogate_out
);

   localparam int DW   = lifsg_pkg::DATA_W;
   localparam int VW   = VALUE_WIDTH;
   localparam int RW   = REFRACTORY_WIDTH;
   localparam int SHD  = lifsg_pkg::GAIN_FRAC;
   localparam int SHG  = lifsg_pkg::GAIN_FRAC + lifsg_pkg::IN_FRAC - FRAC_BITS;
   localparam int SHS  = lifsg_pkg::SG_EXTRA + FRAC_BITS;
   localparam int P1W  = VW + lifsg_pkg::DECAY_W + 1;
   localparam int PGW  = lifsg_pkg::GAIN_W + 1 + DW;
   localparam int XW   = ((P1W > PGW) ? P1W : PGW) + 1;
   localparam int SW   = (((VW + 1) > (PGW + 1 - SHG)) ? (VW + 1) : (PGW + 1 - SHG)) + 3;
   localparam int SLW  = 2 * DW + 1;

   localparam logic signed [XW-1:0]  HALF_D = {{(XW-1){1'b0}}, 1'b1} << (SHD - 1);
   localparam logic signed [XW-1:0]  HALF_G = {{(XW-1){1'b0}}, 1'b1} << (SHG - 1);
   localparam logic signed [SLW-1:0] HALF_S = {{(SLW-1){1'b0}}, 1'b1} << (SHS - 1);
   localparam logic signed [SW-1:0]  VMAX   = SW'({1'b0, {(VW-1){1'b1}}});
   localparam logic signed [SW-1:0]  VMIN   = ~VMAX;
   localparam logic signed [SW-1:0]  M32MAX = SW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [SW-1:0]  M32MIN = ~M32MAX;
   localparam logic signed [SLW-1:0] S32MAX = SLW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [SLW-1:0] S32MIN = ~S32MAX;

   // neuron state
   logic signed [VW-1:0]  membrane_ff;
   logic                  last_spike_ff;
   logic [RW-1:0]         refr_ff;
   logic signed [DW-1:0]  held_ff;

   // per-tick working registers
   logic signed [P1W-1:0] p1_ff;
   logic signed [PGW-1:0] p2_ff;
   logic signed [PGW-1:0] p3_ff;
   logic [DW-1:0]         mem32_ff;
   logic [DW-1:0]         diff_ff;
   logic                  sg_en_ff;

   // result word
   logic                  spike_out_ff;
   logic [DW-1:0]         membrane_out_ff;
   logic [DW-1:0]         surrogate_out_ff;

   logic                  clear_now;
   logic signed [P1W-1:0] p1_prod;
   logic signed [P1W-1:0] p1_in;
   logic signed [PGW-1:0] p2_prod;
   logic signed [PGW-1:0] p3_prod;
   logic signed [DW:0]    held_sum;
   logic signed [DW-1:0]  held_in;

   logic signed [XW-1:0]  x1, x2, x3;
   logic signed [XW-1:0]  a1, a2, a3;
   logic signed [XW-1:0]  r1, r2, r3;
   logic signed [SW-1:0]  thr_ext;
   logic signed [SW-1:0]  flr_ext;
   logic signed [SW-1:0]  thr_sub;
   logic signed [SW-1:0]  v_sum;
   logic signed [SW-1:0]  v_cl;
   logic signed [SW-1:0]  v_sat;
   logic signed [SW-1:0]  m32;
   logic signed [SW-1:0]  d_val;
   logic signed [SW-1:0]  d_abs;
   logic signed [SW-1:0]  t_abs;
   logic signed [SW-1:0]  diff;
   logic                  refr_zero;
   logic                  fire;
   logic [RW-1:0]         steps_cut;
   logic [RW-1:0]         refr_load;
   logic [RW-1:0]         refr_in;

   logic signed [SLW-1:0] s_prod;
   logic signed [SLW-1:0] s_adj;
   logic signed [SLW-1:0] s_rnd;
   logic [DW-1:0]         sg_val;

   // capture: gain products and the next held current
   assign clear_now = cmd.capture && req_clear_state;
   assign p1_prod   = $signed({1'b0, csr.decay_v}) * membrane_ff;
   assign p2_prod   = $signed({1'b0, csr.current_gain}) * held_ff;
   assign p3_prod   = $signed({1'b0, csr.spike_gain}) * $signed(req_spike_input);

   always_comb begin
      if (clear_now) begin
         p1_in = '0;
      end else begin
         p1_in = p1_prod;
      end
   end

   assign held_sum = $signed({req_current_input[DW-1], req_current_input})
                   + $signed({csr.bias_current[DW-1], csr.bias_current});

   always_comb begin
      if (held_sum[DW] != held_sum[DW-1]) begin
         held_in = held_sum[DW] ? $signed({1'b1, {(DW-1){1'b0}}})
                                : $signed({1'b0, {(DW-1){1'b1}}});
      end else begin
         held_in = held_sum[DW-1:0];
      end
   end

   // round each product to nearest, ties away from zero
   assign x1 = XW'(p1_ff);
   assign x2 = XW'(p2_ff);
   assign x3 = XW'(p3_ff);
   assign a1 = x1 + HALF_D - $signed({{(XW-1){1'b0}}, x1[XW-1]});
   assign a2 = x2 + HALF_G - $signed({{(XW-1){1'b0}}, x2[XW-1]});
   assign a3 = x3 + HALF_G - $signed({{(XW-1){1'b0}}, x3[XW-1]});
   assign r1 = a1 >>> SHD;
   assign r2 = a2 >>> SHG;
   assign r3 = a3 >>> SHG;

   // membrane sum, threshold reset, floor clamp, saturation
   assign thr_ext = SW'($signed(csr.v_threshold));
   assign flr_ext = SW'($signed(csr.v_floor));

   always_comb begin
      if (last_spike_ff) begin
         thr_sub = thr_ext;
      end else begin
         thr_sub = '0;
      end
   end

   assign v_sum = SW'(r1) + SW'(r2) + SW'(r3) - thr_sub;
   assign v_cl  = (v_sum < flr_ext) ? flr_ext : v_sum;

   always_comb begin
      if (v_cl > VMAX) begin
         v_sat = VMAX;
      end else if (v_cl < VMIN) begin
         v_sat = VMIN;
      end else begin
         v_sat = v_cl;
      end
   end

   always_comb begin
      if (v_sat > M32MAX) begin
         m32 = M32MAX;
      end else if (v_sat < M32MIN) begin
         m32 = M32MIN;
      end else begin
         m32 = v_sat;
      end
   end

   // distance of the membrane from the threshold
   assign d_val = v_sat - thr_ext;
   assign d_abs = (d_val < 0) ? -d_val : d_val;
   assign t_abs = (thr_ext < 0) ? -thr_ext : thr_ext;
   assign diff  = t_abs - d_abs;

   // firing and refractory countdown
   assign refr_zero = (refr_ff == '0);
   assign fire      = (v_sat >= thr_ext) && refr_zero;
   assign steps_cut = RW'(csr.refractory_steps);
   assign refr_load = fire ? steps_cut : refr_ff;
   assign refr_in   = (refr_load != '0) ? (refr_load - 1'b1) : refr_load;

   // surrogate product, rounding and saturation to 32 bits
   assign s_prod = $signed(csr.sg_slope) * $signed({1'b0, diff_ff});
   assign s_adj  = s_prod + HALF_S - $signed({{(SLW-1){1'b0}}, s_prod[SLW-1]});
   assign s_rnd  = s_adj >>> SHS;

   always_comb begin
      if (!sg_en_ff) begin
         sg_val = '0;
      end else if (s_rnd > S32MAX) begin
         sg_val = S32MAX[DW-1:0];
      end else if (s_rnd < S32MIN) begin
         sg_val = S32MIN[DW-1:0];
      end else begin
         sg_val = s_rnd[DW-1:0];
      end
   end

   // neuron state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         membrane_ff   <= '0;
         last_spike_ff <= 1'b0;
         refr_ff       <= '0;
         held_ff       <= '0;
      end else begin
         if (cmd.capture) begin
            held_ff <= held_in;
         end
         if (clear_now) begin
            last_spike_ff <= 1'b0;
            refr_ff       <= '0;
         end
         if (cmd.update) begin
            membrane_ff   <= v_sat[VW-1:0];
            last_spike_ff <= fire;
            refr_ff       <= refr_in;
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         p1_ff <= p1_in;
         p2_ff <= p2_prod;
         p3_ff <= p3_prod;
      end
      if (cmd.update) begin
         mem32_ff <= m32[DW-1:0];
         diff_ff  <= diff[DW-1:0];
         sg_en_ff <= refr_zero && (diff > 0);
      end
      if (cmd.finish) begin
         spike_out_ff     <= last_spike_ff;
         membrane_out_ff  <= mem32_ff;
         surrogate_out_ff <= sg_val;
      end
   end

   assign rsp_spike_out     = spike_out_ff;
   assign rsp_membrane_out  = membrane_out_ff;
   assign rsp_surrogate_out = surrogate_out_ff;

   // checks
   `LIFSG_ASSERT_NOW(a_spike_from_update, clock, reset, $rose(last_spike_ff), $past(cmd.update), "spike flag set outside membrane update")
   `LIFSG_ASSERT_NEXT(a_clear_refractory, clock, reset, clear_now, refr_ff == '0, "clear left refractory count")

endmodule

// ===== bench/lif_neuron_surrogate_gradient_test.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_surrogate_gradient_test
// self-checking bench for the lif neuron tick: a cycle-free predictor of the
// membrane, spike, refractory and surrogate chain checks every response word
// under directed extremes, several register settings, random ticks,
// random idling on both streams and a long response hold-off
// ----------------------------------------------------------------------------
module lif_neuron_surrogate_gradient_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lifsg_pkg::*;

   localparam int     FRAC_BITS    = 16;
   localparam int     DRAIN_CYCLES = 8;
   localparam longint WORD_MAX     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint WORD_MIN     = -64'sh0000_0000_8000_0000;
   localparam logic [31:0] THR_DEFAULT = 32'd983040;

   // one predicted response word
   typedef struct {
      logic        spike;
      logic [31:0] membrane;
      logic [31:0] surrogate;
   } tick_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;

   // predicted neuron state and register copy
   csr_type             nrn_cfg;
   longint              nrn_membrane;
   logic                nrn_last_spike;
   logic [STEPS_W-1:0]  nrn_refractory;
   longint              nrn_held;
   tick_result_type     pending_ticks[$];

   int  mismatch_count = 0;
   bit  gaps_on        = 1'b0;
   bit  stalls_on      = 1'b0;
   int  hold_request   = 0;

   lif_neuron_surrogate_gradient u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // spike_input, current_input
      .req_tuser  (req_tuser),   // clear_state
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // membrane_out, surrogate_out
      .rsp_tuser  (rsp_tuser),   // spike_out
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // product scaled down by 2^shift, rounded half away from zero, held to int64
   function automatic longint round_product(longint a, longint b, int unsigned shift);
      logic [63:0]  mag_a;
      logic [63:0]  mag_b;
      logic [127:0] prod;
      logic         neg;
      neg   = (a < 0) != (b < 0);
      mag_a = (a < 0) ? -a : a;
      mag_b = (b < 0) ? -b : b;
      prod  = {64'd0, mag_a} * {64'd0, mag_b};
      prod  = (prod + (128'd1 << (shift - 1))) >> shift;
      if (prod > 128'h7FFF_FFFF_FFFF_FFFF)
         prod = 128'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX)
         return WORD_MAX;
      if (v < WORD_MIN)
         return WORD_MIN;
      return v;
   endfunction

   function automatic csr_type reset_config();
      csr_type c;
      c.decay_v          = RST_DECAY_V;
      c.current_gain     = RST_CURRENT_GAIN;
      c.spike_gain       = RST_SPIKE_GAIN;
      c.v_threshold      = RST_V_THRESHOLD;
      c.v_floor          = RST_V_FLOOR;
      c.refractory_steps = RST_REFRACTORY_STEPS;
      c.sg_slope         = RST_SG_SLOPE;
      c.bias_current     = RST_BIAS_CURRENT;
      return c;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] index, logic [DATA_W-1:0] data);
      case (index)
         CSR_DECAY_V:          nrn_cfg.decay_v          = data[DECAY_W-1:0];
         CSR_CURRENT_GAIN:     nrn_cfg.current_gain     = data[GAIN_W-1:0];
         CSR_SPIKE_GAIN:       nrn_cfg.spike_gain       = data[GAIN_W-1:0];
         CSR_V_THRESHOLD:      nrn_cfg.v_threshold      = data;
         CSR_V_FLOOR:          nrn_cfg.v_floor          = data;
         CSR_REFRACTORY_STEPS: nrn_cfg.refractory_steps = data[STEPS_W-1:0];
         CSR_SG_SLOPE:         nrn_cfg.sg_slope         = data;
         CSR_BIAS_CURRENT:     nrn_cfg.bias_current     = data;
         default: ;
      endcase
   endfunction

   // one neuron tick: membrane update, surrogate, spike, refractory, held current
   function automatic tick_result_type predict_tick(logic [31:0] spike_word,
                                                    logic [31:0] current_word,
                                                    logic clear);
      tick_result_type res;
      longint spk;
      longint cur;
      longint thr;
      longint flr;
      longint v;
      longint offset;
      longint room;
      logic   fire;
      spk = longint'($signed(spike_word));
      cur = longint'($signed(current_word));
      thr = longint'($signed(nrn_cfg.v_threshold));
      flr = longint'($signed(nrn_cfg.v_floor));
      if (clear) begin
         nrn_membrane   = 0;
         nrn_last_spike = 1'b0;
         nrn_refractory = '0;
      end
      v = round_product(longint'(nrn_cfg.decay_v), nrn_membrane, GAIN_FRAC)
        + round_product(longint'(nrn_cfg.current_gain), nrn_held,
                        GAIN_FRAC + IN_FRAC - FRAC_BITS)
        + round_product(longint'(nrn_cfg.spike_gain), spk,
                        GAIN_FRAC + IN_FRAC - FRAC_BITS);
      if (nrn_last_spike)
         v = v - thr;
      if (v < flr)
         v = flr;
      v = clamp_word(v);
      nrn_membrane = v;
      // triangle around the threshold, silent while refractory
      res.surrogate = '0;
      if (nrn_refractory == 0) begin
         offset = v - thr;
         room   = (thr < 0 ? -thr : thr) - (offset < 0 ? -offset : offset);
         if (room > 0)
            res.surrogate = 32'(clamp_word(round_product(longint'($signed(nrn_cfg.sg_slope)),
                                                         room, SG_EXTRA + FRAC_BITS)));
      end
      fire = (v >= thr) && (nrn_refractory == 0);
      if (fire)
         nrn_refractory = nrn_cfg.refractory_steps;
      if (nrn_refractory != 0)
         nrn_refractory = nrn_refractory - 1'b1;
      nrn_last_spike = fire;
      nrn_held = clamp_word(cur + longint'($signed(nrn_cfg.bias_current)));
      res.spike    = fire;
      res.membrane = 32'(v);
      return res;
   endfunction

   // follow register writes and accepted words
   always @(posedge clock) begin
      if (reset) begin
         nrn_cfg        = reset_config();
         nrn_membrane   = 0;
         nrn_last_spike = 1'b0;
         nrn_refractory = '0;
         nrn_held       = 0;
         pending_ticks.delete();
      end else begin
         if (csr_we)
            apply_csr(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            pending_ticks.push_back(predict_tick(req_tdata[31:0], req_tdata[63:32],
                                                 req_tuser));
      end
   end

   // ------------------------------------------------------------------ checker

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch %s at %0t ns: expected %h got %h", field, $time, want, got);
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ticks.size() == 0) begin
            report_mismatch("unexpected word", 32'd0, rsp_tdata[31:0]);
         end else begin
            want = pending_ticks.pop_front();
            if (rsp_tuser !== want.spike)
               report_mismatch("spike_out", 32'(want.spike), 32'(rsp_tuser));
            if (rsp_tdata[31:0] !== want.membrane)
               report_mismatch("membrane_out", want.membrane, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== want.surrogate)
               report_mismatch("surrogate_out", want.surrogate, rsp_tdata[63:32]);
         end
      end
   end

   // ------------------------------------------------------------ idling helpers

   // mostly short gaps, a few long ones
   function automatic int gap_length(int least);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(least, 3);
      if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // response side: random stalls plus an occasional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_tready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (gap_length(1)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------ drivers

   task automatic send_tick(logic [31:0] spike_word, logic [31:0] current_word,
                            logic clear);
      int gap;
      req_tdata  <= {current_word, spike_word};
      req_tuser  <= clear;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = 0;
      if (gaps_on && $urandom_range(0, 99) < 45)
         gap = gap_length(1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding word plus pipeline margin
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // narrow registers get random junk above their width
   task automatic write_config(csr_type c);
      logic [31:0] junk;
      junk = $urandom();
      write_reg(CSR_DECAY_V,          {junk[31:DECAY_W], c.decay_v});
      write_reg(CSR_CURRENT_GAIN,     {junk[31:GAIN_W], c.current_gain});
      write_reg(CSR_SPIKE_GAIN,       {~junk[31:GAIN_W], c.spike_gain});
      write_reg(CSR_V_THRESHOLD,      c.v_threshold);
      write_reg(CSR_V_FLOOR,          c.v_floor);
      write_reg(CSR_REFRACTORY_STEPS, {~junk[31:STEPS_W], c.refractory_steps});
      write_reg(CSR_SG_SLOPE,         c.sg_slope);
      write_reg(CSR_BIAS_CURRENT,     c.bias_current);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [31:0] extreme_word(int k);
      case (k % 5)
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // signed value of random scale, some raw and extreme words mixed in
   function automatic logic [31:0] random_word(int neg_pct);
      int r;
      int scale;
      logic [31:0] mag;
      r = $urandom_range(0, 99);
      if (r < 15)
         return $urandom();
      if (r < 20)
         return extreme_word($urandom_range(0, 4));
      scale = $urandom_range(8, 22);
      mag   = $urandom_range(0, 1 << scale);
      return ($urandom_range(0, 99) < neg_pct) ? -mag : mag;
   endfunction

   function automatic csr_type random_config();
      csr_type c;
      logic [31:0] thr_mag;
      c.decay_v = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                              : 16'($urandom_range(52000, 65535));
      c.current_gain = 24'($urandom_range(0, 1 << 20));
      c.spike_gain   = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                                   : 24'($urandom_range(0, 1 << 18));
      thr_mag = $urandom_range(1 << 14, 1 << 22);
      case ($urandom_range(0, 9))
         0:       c.v_threshold = -thr_mag;
         1:       c.v_threshold = '0;
         default: c.v_threshold = thr_mag;
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2: c.v_floor = 32'h8000_0000;
         3:       c.v_floor = c.v_threshold + 32'($urandom_range(1, 1 << 16));
         default: c.v_floor = -32'($urandom_range(0, 1 << 23));
      endcase
      c.refractory_steps = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                       : 16'($urandom_range(0, 25));
      c.sg_slope     = $urandom();
      c.bias_current = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 1 << 16))
                                                   : -32'($urandom_range(0, 1 << 16));
      return c;
   endfunction

   task automatic send_random_tick();
      send_tick(random_word(30), random_word(50), $urandom_range(0, 39) == 0);
   endtask

   // defaults after reset: firing, refractory, surrogate on both sides, saturation
   task automatic test_reset_defaults();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_tick(32'd0, 32'd0, 1'b0);
      send_tick(THR_DEFAULT, 32'd0, 1'b1);
      send_tick(32'd0, 32'd0, 1'b0);
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_tick(32'd0, 32'h8000_0000, 1'b0);
      send_tick(32'h8000_0000, 32'd0, 1'b1);
      send_tick(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_tick(THR_DEFAULT - 32'd65536, 32'd0, 1'b1);
      send_tick(32'd0, 32'hFFFF_FFFF, 1'b1);
      send_tick(THR_DEFAULT + 32'd327680, 32'd1, 1'b1);
      send_tick(32'd1, 32'd0, 1'b1);
      send_tick(-THR_DEFAULT, 32'd0, 1'b1);
      wait_results_drained();
   endtask

   // widest, zero and inverted register settings
   task automatic test_register_extremes();
      csr_type c;
      // all registers but the floor at their top, floor at its bottom, surrogate saturates
      c.decay_v          = 16'hFFFF;
      c.current_gain     = 24'hFF_FFFF;
      c.spike_gain       = 24'hFF_FFFF;
      c.v_threshold      = 32'h7FFF_FFFF;
      c.v_floor          = 32'h8000_0000;
      c.refractory_steps = 16'hFFFF;
      c.sg_slope         = 32'h7FFF_FFFF;
      c.bias_current     = 32'h7FFF_FFFF;
      write_config(c);
      for (int k = 0; k < 5; k++)
         send_tick(extreme_word(k + 1), extreme_word(k + 3), k == 0);
      wait_results_drained();
      // zero threshold: surrogate stays zero
      c = '0;
      c.bias_current = 32'h8000_0000;
      write_config(c);
      for (int k = 0; k < 5; k++)
         send_tick(extreme_word(k), extreme_word(k + 2), k == 3);
      wait_results_drained();
      // negative threshold with the floor above it
      c.decay_v          = 16'd32768;
      c.current_gain     = 24'd65536;
      c.spike_gain       = 24'd65536;
      c.v_threshold      = -32'd1048576;
      c.v_floor          = 32'd262144;
      c.refractory_steps = 16'd3;
      c.sg_slope         = 32'h8000_0000;
      c.bias_current     = -32'd65536;
      write_config(c);
      for (int k = 0; k < 6; k++)
         send_tick(extreme_word(k + 2), random_word(50), k == 4);
      wait_results_drained();
   endtask

   // response held off long enough for the block to stall its input
   task automatic test_backpressure();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_config(random_config());
      hold_request = 300;
      repeat (40) send_random_tick();
      wait_results_drained();
   endtask

   // random settings, each followed by a burst of random ticks
   task automatic test_random_ticks();
      for (int phase = 0; phase < 8; phase++) begin
         write_config(phase == 0 ? reset_config() : random_config());
         gaps_on   = (phase % 3) != 1;
         stalls_on = (phase % 3) != 2;
         repeat (170) send_random_tick();
         wait_results_drained();
      end
   endtask

   // ------------------------------------------------------------------ main

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_ticks();
      wait_results_drained();
      if (pending_ticks.size() != 0)
         report_mismatch("missing words", 32'(pending_ticks.size()), 32'd0);
      if (mismatch_count == 0) begin
         $display("lif_neuron_surrogate_gradient test passed");
      end else begin
         $display("lif_neuron_surrogate_gradient test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("lif_neuron_surrogate_gradient test failed");
      $finish;
   end

endmodule
